[rtl/box_blur_3x3_macros.svh]
// Assertion helpers for the box blur block.
// Both sample on clk_i and are muted while rst_ni is low.
`ifndef BOX_BLUR_3X3_MACROS_SVH
`define BOX_BLUR_3X3_MACROS_SVH

// Property must hold at every sampled edge.
`define BB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition must never be seen true.
`define BB_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[rtl/bb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bb_pkg;

  localparam int PIX_W   = 8;
  localparam int FW_W    = 12;   // frame_width register
  localparam int FH_W    = 16;   // frame_height register, row counter
  localparam int OCOL_W  = 11;
  localparam int SUM_W   = 12;   // nine 8-bit samples
  localparam int NUM_W   = SUM_W + 1;
  localparam int CNT_W   = 4;    // neighbour count, 1..9
  localparam int RCP_W   = 20;
  localparam int RCP_SH  = 20;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [FW_W-1:0] FW_RESET = 12'd640;
  localparam logic [FH_W-1:0] FH_RESET = 16'd480;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_red;
    logic [PIX_W-1:0] pixel_green;
    logic [PIX_W-1:0] pixel_blue;
  } pix_t;

  typedef struct packed {
    logic [FH_W-1:0]   out_row;
    logic [OCOL_W-1:0] out_col;
    logic [PIX_W-1:0]  out_red;
    logic [PIX_W-1:0]  out_green;
    logic [PIX_W-1:0]  out_blue;
    logic              run_last;
    logic              frame_done;
  } res_t;

  // Which window rows / columns belong to the current output's neighbourhood
  typedef struct packed {
    logic [2:0] row_ok;
    logic [2:0] col_ok;
  } bb_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RD   = 4'b0010,
    ST_SUM  = 4'b0100,
    ST_MUL  = 4'b1000
  } bb_state_e;

  // ceil(2^20 / (2n)); exact quotient for numerators below 2^13
  function automatic logic [RCP_W-1:0] bb_recip(input logic [CNT_W-1:0] n);
    logic [RCP_W-1:0] m;
    case (n)
      4'd1:    m = 20'd524288;
      4'd2:    m = 20'd262144;
      4'd3:    m = 20'd174763;
      4'd4:    m = 20'd131072;
      4'd6:    m = 20'd87382;
      4'd9:    m = 20'd58255;
      default: m = 20'd524288;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

[rtl/bb_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module bb_ram #(
  parameter int DATA_W = 48,
  parameter int DEPTH  = 2048,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AW-1:0]     waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic [AW-1:0]     raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/bb_avg.sv]
`timescale 1ns / 1ps
`default_nettype none

module bb_avg
  import bb_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               load_i,
  input  wire bb_sel_t            sel_i,
  input  wire pix_t [2:0][2:0]    win_i,
  output pix_t                    avg_o
);

  logic [SUM_W-1:0] sum_r_d, sum_g_d, sum_b_d;
  logic [SUM_W-1:0] sum_r_q, sum_g_q, sum_b_q;
  logic [CNT_W-1:0] n_d, n_q;
  logic [1:0]       nr, nc;
  logic [NUM_W-1:0] num_r, num_g, num_b;
  logic [RCP_W-1:0] rcp;
  logic [NUM_W+RCP_W-1:0] prod_r, prod_g, prod_b;

  // masked sums over the window
  always_comb begin
    sum_r_d = '0;
    sum_g_d = '0;
    sum_b_d = '0;
    for (int s = 0; s < 3; s++) begin
      for (int t = 0; t < 3; t++) begin
        if (sel_i.row_ok[s] && sel_i.col_ok[t]) begin
          sum_r_d = sum_r_d + SUM_W'(win_i[s][t].pixel_red);
          sum_g_d = sum_g_d + SUM_W'(win_i[s][t].pixel_green);
          sum_b_d = sum_b_d + SUM_W'(win_i[s][t].pixel_blue);
        end
      end
    end
    nr  = 2'(sel_i.row_ok[0]) + 2'(sel_i.row_ok[1]) + 2'(sel_i.row_ok[2]);
    nc  = 2'(sel_i.col_ok[0]) + 2'(sel_i.col_ok[1]) + 2'(sel_i.col_ok[2]);
    n_d = CNT_W'(nr) * CNT_W'(nc);
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sum_r_q <= sum_r_d;
      sum_g_q <= sum_g_d;
      sum_b_q <= sum_b_d;
      n_q     <= n_d;
    end
  end

  // (2*sum + n) / (2n) by reciprocal multiply
  always_comb begin
    rcp    = bb_recip(n_q);
    num_r  = {sum_r_q, 1'b0} + NUM_W'(n_q);
    num_g  = {sum_g_q, 1'b0} + NUM_W'(n_q);
    num_b  = {sum_b_q, 1'b0} + NUM_W'(n_q);
    prod_r = (NUM_W+RCP_W)'(num_r) * (NUM_W+RCP_W)'(rcp);
    prod_g = (NUM_W+RCP_W)'(num_g) * (NUM_W+RCP_W)'(rcp);
    prod_b = (NUM_W+RCP_W)'(num_b) * (NUM_W+RCP_W)'(rcp);
    avg_o.pixel_red   = prod_r[RCP_SH +: PIX_W];
    avg_o.pixel_green = prod_g[RCP_SH +: PIX_W];
    avg_o.pixel_blue  = prod_b[RCP_SH +: PIX_W];
  end

endmodule

`default_nettype wire

[rtl/box_blur_3x3.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "box_blur_3x3_macros.svh"
// 3x3 box blur with edge clipping for a raster-order RGB stream.
// Input channel: in_valid_i / in_stall_o with one pixel item per handshake.
// Output channel: out_valid_o / out_stall_i; each item carries row, column,
// the rounded mean of the in-frame neighbours and run_last / frame_done.
// An input causes zero to four output items; run_last marks the last one.
// Config: cfg_valid_i / cfg_ready_o, index 0 frame_width, 1 frame_height.
// A write restarts the frame at row 0, column 0. Write only when idle.
// Steps: an input passes a line store read, then write-back and window
// shift; each output then passes a masked sum and a reciprocal multiply.
// The rate is set by the single averaging unit shared by all outputs.
// The output register holds an item while out_stall_i is high; the block
// stops at the multiply step until it frees, and in_stall_o stays high
// until the current input's outputs are all in the register.
// Reset: width 640, height 480, position and window cleared. The line store
// is not cleared; entries outside the current frame never reach a result.
module box_blur_3x3
  import bb_pkg::*;
#(
  parameter int MAX_LINE = 2048
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire pix_t                  in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output res_t                       out_data_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int CW = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
  localparam int EW = (CW + 1 > FW_W) ? CW + 1 : FW_W;
  localparam int LS_W = 2 * $bits(pix_t);

  bb_state_e state_q, state_d;

  logic [FW_W-1:0] fwidth_q;
  logic [FH_W-1:0] fheight_q;
  logic [EW-1:0]   w_eff, w_last;
  logic [FH_W-1:0] h_last;

  logic [CW-1:0]   col_q, icol_q, ocol_q;
  logic [FH_W-1:0] row_q, irow_q, orow_q;
  pix_t            px_q;
  pix_t [2:0][2:0] win_q;
  logic [3:0]      pend_q, pend_new, kbit, kbit_q, rest;
  logic            last_q, done_q;

  logic            in_acc, cfg_we, is_last_col, is_last_row, slot_free;
  logic [LS_W-1:0] ls_rdata;
  pix_t            older, newer;
  logic            dr_up, dc_left;
  bb_sel_t         sel;
  pix_t            avg;
  logic            out_valid_q;
  res_t            out_data_q;

  // handshakes
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;
  assign slot_free   = !out_valid_q || !out_stall_i;

  // effective frame size
  always_comb begin
    if (fwidth_q == '0) begin
      w_eff = EW'(1);
    end else if (EW'(fwidth_q) > EW'(MAX_LINE)) begin
      w_eff = EW'(MAX_LINE);
    end else begin
      w_eff = EW'(fwidth_q);
    end
    w_last = w_eff - EW'(1);
    h_last = (fheight_q == '0) ? '0 : fheight_q - FH_W'(1);
  end

  assign is_last_col = (EW'(col_q) == w_last);
  assign is_last_row = (row_q == h_last);
  assign pend_new = {is_last_row && is_last_col,
                     is_last_row && (col_q != '0),
                     (row_q != '0) && is_last_col,
                     (row_q != '0) && (col_q != '0)};

  // line store: {older row, newer row} per column
  assign older = pix_t'(ls_rdata[LS_W-1 -: $bits(pix_t)]);
  assign newer = pix_t'(ls_rdata[$bits(pix_t)-1:0]);

  bb_ram #(
    .DATA_W (LS_W),
    .DEPTH  (MAX_LINE)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_RD),
    .waddr_i (col_q),
    .wdata_i ({newer, px_q}),
    .raddr_i (col_q),
    .rdata_o (ls_rdata)
  );

  // pick the next pending output, lowest index first
  always_comb begin
    kbit    = pend_q & (~pend_q + 4'd1);
    rest    = pend_q & ~kbit;
    dr_up   = kbit[0] || kbit[1];
    dc_left = kbit[0] || kbit[2];
    if (irow_q >= FH_W'(2)) begin
      sel.row_ok = 3'b111;
    end else if (irow_q == FH_W'(1)) begin
      sel.row_ok = 3'b110;
    end else begin
      sel.row_ok = 3'b100;
    end
    if (!dr_up) begin
      sel.row_ok = sel.row_ok & 3'b110;
    end
    if (EW'(icol_q) >= EW'(2)) begin
      sel.col_ok = 3'b111;
    end else if (EW'(icol_q) == EW'(1)) begin
      sel.col_ok = 3'b110;
    end else begin
      sel.col_ok = 3'b100;
    end
    if (!dc_left) begin
      sel.col_ok = sel.col_ok & 3'b110;
    end
  end

  bb_avg u_avg (
    .clk_i  (clk_i),
    .load_i (state_q == ST_SUM),
    .sel_i  (sel),
    .win_i  (win_q),
    .avg_o  (avg)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        state_d = (pend_new != '0) ? ST_SUM : ST_IDLE;
      end
      ST_SUM: begin
        state_d = ST_MUL;
      end
      ST_MUL: begin
        if (slot_free) begin
          state_d = ((pend_q & ~kbit_q) != '0) ? ST_SUM : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control state, configuration, window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fwidth_q    <= FW_RESET;
      fheight_q   <= FH_RESET;
      col_q       <= '0;
      row_q       <= '0;
      win_q       <= '0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we) begin
        unique case (cfg_index_i)
          REG_FRAME_WIDTH:  fwidth_q  <= cfg_wdata_i[FW_W-1:0];
          REG_FRAME_HEIGHT: fheight_q <= cfg_wdata_i[FH_W-1:0];
          default:          ;
        endcase
        col_q <= '0;
        row_q <= '0;
        win_q <= '0;
      end else if (state_q == ST_RD) begin
        for (int k = 0; k < 3; k++) begin
          win_q[k][0] <= win_q[k][1];
          win_q[k][1] <= win_q[k][2];
        end
        win_q[0][2] <= older;
        win_q[1][2] <= newer;
        win_q[2][2] <= px_q;
        if (is_last_col) begin
          col_q <= '0;
          row_q <= is_last_row ? '0 : row_q + FH_W'(1);
        end else begin
          col_q <= col_q + CW'(1);
        end
      end
      if (state_q == ST_RD) begin
        pend_q <= pend_new;
      end else if (state_q == ST_MUL && slot_free) begin
        pend_q <= pend_q & ~kbit_q;
      end
      if (state_q == ST_MUL && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item payload and per-output tags
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      px_q <= in_data_i;
    end
    if (state_q == ST_RD) begin
      irow_q <= row_q;
      icol_q <= col_q;
    end
    if (state_q == ST_SUM) begin
      orow_q <= dr_up ? irow_q - FH_W'(1) : irow_q;
      ocol_q <= dc_left ? icol_q - CW'(1) : icol_q;
      last_q <= (rest == '0);
      done_q <= kbit[3];
      kbit_q <= kbit;
    end
    if (state_q == ST_MUL && slot_free) begin
      out_data_q.out_row    <= orow_q;
      out_data_q.out_col    <= OCOL_W'(ocol_q);
      out_data_q.out_red    <= avg.pixel_red;
      out_data_q.out_green  <= avg.pixel_green;
      out_data_q.out_blue   <= avg.pixel_blue;
      out_data_q.run_last   <= last_q;
      out_data_q.frame_done <= done_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // checks
  `BB_ASSERT(a_acc_to_rd, in_valid_i && !in_stall_o |=> state_q == ST_RD, "accept did not read")
  `BB_NEVER(a_idle_pend, state_q == ST_IDLE && pend_q != '0, "outputs left pending")
  `BB_ASSERT(a_done_last, out_valid_o && out_data_o.frame_done |-> out_data_o.run_last, "done without last")
  `BB_NEVER(a_col_range, EW'(col_q) >= w_eff, "column past frame width")

endmodule

`default_nettype wire
